@@ design/keyed_counter_delta_table_assert.svh @@
// Assertion macros shared by the keyed counter delta table RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef KEYED_COUNTER_DELTA_TABLE_ASSERT_SVH
`define KEYED_COUNTER_DELTA_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define KCDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define KCDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KCDT_ASSERT(lbl, prop, msg)
`define KCDT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ design/kcdt_pkg.sv @@
// Package for the keyed counter delta table: widths, payload structs,
// status codes and the controller/datapath command and status structs.
package kcdt_pkg;

  // Table depth; must be a power of two so the probe address wraps naturally.
  localparam int TableDepth = 4096;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int KeyW       = 23;
  localparam int CntW       = 64;
  localparam int RateW      = 48;
  localparam int PagesW     = 34;
  localparam int KbW        = 36;
  localparam int MsW        = 16;
  localparam int DvdW       = CntW + 10;
  localparam int DivCntW    = $clog2(DvdW);
  localparam int DataW      = KeyW + 2 * CntW;

  localparam logic [31:0]    HashMul     = 32'd2654435761;
  localparam logic [MsW-1:0] DefaultMs   = 16'd1000;

  typedef enum logic [1:0] {
    StReported = 2'd0,
    StFirst    = 2'd1,
    StNoInc    = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0]   process_id;
    logic [CntW-1:0]   minor_faults;
    logic [CntW-1:0]   major_faults;
    logic [PagesW-1:0] resident_pages;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KeyW-1:0]  echo_process_id;
    logic [RateW-1:0] minor_rate;
    logic [RateW-1:0] major_rate;
    logic [KbW-1:0]   resident_kb;
  } out_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic start;
    logic advance;
    logic sel;
    logic mark_full;
    logic div_start;
    logic wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic addr_last;
    logic used;
    logic match;
    logic cnt_last;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

@@ design/keyed_counter_delta_table.sv @@
// Top level of the keyed counter delta table: controller plus datapath.
// Depends on kcdt_pkg, kcdt_ctrl and kcdt_dp.
//
// The block tracks per-process fault counters in a 4096-slot hash table
// (multiplicative hash, linear probing, no deletion) and returns one result
// per input transfer: fault rates per second since the previous sighting of
// the same process id, saturated at 48 bits, plus a status and the resident
// size in kilobytes. After reset the block sweeps the slot-used memory, one
// entry per cycle, and stalls input during that time; configuration writes
// are taken throughout. Each item then walks over the probed slots (one RAM
// read per probe, registered), runs the two rate divisions, which go in
// parallel in a bit-serial divider over the 74-bit scaled difference (a
// start step, 74 quotient bits and a done step), and ends with a write-back
// and an output hand-off; a table-full result skips the divide and the
// write-back. The next item is accepted as soon as the controller is back in
// idle, even while the previous result still waits in the output register.
// Write interval_ms only while the block is idle; zero means 1000 ms.
module keyed_counter_delta_table (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  kcdt_pkg::in_t            in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output kcdt_pkg::out_t           out_data_o,
  input  logic                     cfg_we_i,
  input  logic [kcdt_pkg::MsW-1:0] cfg_wdata_i
);
  // Commands from the controller and status back from the datapath.
  kcdt_pkg::cmd_t cmd;
  kcdt_pkg::sts_t sts;

  kcdt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sts_i(sts), .cmd_o(cmd)
  );

  kcdt_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_data_i, .cfg_we_i, .cfg_wdata_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule

@@ design/kcdt_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module kcdt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

@@ design/kcdt_div.sv @@
// Two-lane restoring divider, one quotient bit per cycle, saturated result.
// Depends on kcdt_pkg.
module kcdt_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [kcdt_pkg::CntW-1:0] diff_a_i,
  input  logic [kcdt_pkg::CntW-1:0] diff_b_i,
  input  logic [kcdt_pkg::MsW-1:0]  ms_i,
  output logic                     done_o,
  output logic [kcdt_pkg::RateW-1:0] rate_a_o,
  output logic [kcdt_pkg::RateW-1:0] rate_b_o
);
  localparam int DvdW = kcdt_pkg::DvdW;
  localparam int MsW  = kcdt_pkg::MsW;

  logic [DvdW-1:0] qa_q, qb_q;
  logic [MsW-1:0]  ra_q, rb_q;
  logic [kcdt_pkg::DivCntW-1:0] cnt_q;
  logic busy_q, done_q;

  // Times 1000 as 1024 - 32 + 8.
  function automatic logic [DvdW-1:0] times1000(input logic [kcdt_pkg::CntW-1:0] d);
    logic [DvdW-1:0] w;
    w = DvdW'(d);
    return (w << 10) - (w << 5) + (w << 3);
  endfunction

  logic [MsW:0] ta, tb;
  assign ta = {ra_q, qa_q[DvdW-1]};
  assign tb = {rb_q, qb_q[DvdW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= kcdt_pkg::DivCntW'(DvdW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qa_q <= times1000(diff_a_i);
      qb_q <= times1000(diff_b_i);
      ra_q <= '0;
      rb_q <= '0;
    end else if (busy_q) begin
      if (ta >= {1'b0, ms_i}) begin
        ra_q <= MsW'(ta - {1'b0, ms_i});
        qa_q <= {qa_q[DvdW-2:0], 1'b1};
      end else begin
        ra_q <= ta[MsW-1:0];
        qa_q <= {qa_q[DvdW-2:0], 1'b0};
      end
      if (tb >= {1'b0, ms_i}) begin
        rb_q <= MsW'(tb - {1'b0, ms_i});
        qb_q <= {qb_q[DvdW-2:0], 1'b1};
      end else begin
        rb_q <= tb[MsW-1:0];
        qb_q <= {qb_q[DvdW-2:0], 1'b0};
      end
    end
  end

  assign done_o   = done_q;
  assign rate_a_o = (|qa_q[DvdW-1:kcdt_pkg::RateW]) ? '1 : qa_q[kcdt_pkg::RateW-1:0];
  assign rate_b_o = (|qb_q[DvdW-1:kcdt_pkg::RateW]) ? '1 : qb_q[kcdt_pkg::RateW-1:0];
endmodule

@@ design/kcdt_dp.sv @@
// Datapath: item registers, hash, probe address, table RAMs, divider,
// interval register and the output register. Depends on kcdt_pkg,
// kcdt_ram and kcdt_div.
module kcdt_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  kcdt_pkg::cmd_t          cmd_i,
  output kcdt_pkg::sts_t          sts_o,
  input  kcdt_pkg::in_t           in_data_i,
  input  logic                    cfg_we_i,
  input  logic [kcdt_pkg::MsW-1:0] cfg_wdata_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output kcdt_pkg::out_t          out_data_o
);
  localparam int AddrW = kcdt_pkg::AddrW;
  localparam int CntW  = kcdt_pkg::CntW;
  localparam int KeyW  = kcdt_pkg::KeyW;

  kcdt_pkg::in_t  item_q;
  kcdt_pkg::out_t out_q;
  logic [AddrW-1:0] addr_q, cnt_q;
  logic [kcdt_pkg::MsW-1:0] interval_q;
  logic [CntW-1:0] dmin_q, dmaj_q;
  logic first_q, min_up_q, maj_up_q, full_q, out_valid_q;

  logic used_rd, used_wd, used_we;
  logic [kcdt_pkg::DataW-1:0] data_rd, data_wd;
  logic [KeyW-1:0] rd_key;
  logic [CntW-1:0] rd_min, rd_maj, pmin, pmaj;
  logic [31:0] hash;
  logic [kcdt_pkg::MsW-1:0] ms;
  logic div_done;
  logic [kcdt_pkg::RateW-1:0] rate_min, rate_maj;
  logic min_ok, maj_ok;
  logic [1:0] status;

  assign hash = 32'({9'b0, item_q.process_id} * kcdt_pkg::HashMul);
  assign ms   = (interval_q == '0) ? kcdt_pkg::DefaultMs : interval_q;

  assign {rd_key, rd_min, rd_maj} = data_rd;
  // A free slot holds zero counters for the item that claims it.
  assign pmin   = used_rd ? rd_min : '0;
  assign pmaj   = used_rd ? rd_maj : '0;
  assign min_ok = (pmin != '0) && (item_q.minor_faults >= pmin);
  assign maj_ok = (pmaj != '0) && (item_q.major_faults >= pmaj);

  assign used_we = cmd_i.clr || cmd_i.wr;
  assign used_wd = cmd_i.wr;
  assign data_wd = {item_q.process_id,
                    (item_q.minor_faults == '0) ? CntW'(1) : item_q.minor_faults,
                    (item_q.major_faults == '0) ? CntW'(1) : item_q.major_faults};

  kcdt_ram #(.Width(1), .Depth(kcdt_pkg::TableDepth)) u_used_ram (
    .clk_i, .addr_i(addr_q), .we_i(used_we), .wdata_i(used_wd), .rdata_o(used_rd)
  );

  kcdt_ram #(.Width(kcdt_pkg::DataW), .Depth(kcdt_pkg::TableDepth)) u_data_ram (
    .clk_i, .addr_i(addr_q), .we_i(cmd_i.wr), .wdata_i(data_wd), .rdata_o(data_rd)
  );

  kcdt_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .diff_a_i(dmin_q), .diff_b_i(dmaj_q),
    .ms_i(ms), .done_o(div_done), .rate_a_o(rate_min), .rate_b_o(rate_maj)
  );

  always_comb begin
    if (full_q) begin
      status = kcdt_pkg::StFull;
    end else if (first_q) begin
      status = kcdt_pkg::StFirst;
    end else if (!min_up_q && !maj_up_q) begin
      status = kcdt_pkg::StNoInc;
    end else begin
      status = kcdt_pkg::StReported;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      cnt_q       <= '0;
      interval_q  <= kcdt_pkg::DefaultMs;
      out_valid_q <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      if (cmd_i.clr || cmd_i.advance) begin
        addr_q <= addr_q + 1'b1;
      end else if (cmd_i.start) begin
        addr_q <= hash[AddrW-1:0];
      end
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.advance) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.load) begin
        full_q <= 1'b0;
      end else if (cmd_i.mark_full) begin
        full_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.sel) begin
      first_q  <= (pmin == '0) && (pmaj == '0);
      min_up_q <= min_ok && (item_q.minor_faults != pmin);
      maj_up_q <= maj_ok && (item_q.major_faults != pmaj);
      dmin_q   <= min_ok ? item_q.minor_faults - pmin : '0;
      dmaj_q   <= maj_ok ? item_q.major_faults - pmaj : '0;
    end
    if (cmd_i.finish) begin
      out_q.status          <= status;
      out_q.echo_process_id <= item_q.process_id;
      out_q.minor_rate      <= full_q ? '0 : rate_min;
      out_q.major_rate      <= full_q ? '0 : rate_maj;
      out_q.resident_kb     <= {item_q.resident_pages, 2'b00};
    end
  end

  assign sts_o.addr_last = (addr_q == AddrW'(kcdt_pkg::TableDepth - 1));
  assign sts_o.used      = used_rd;
  assign sts_o.match     = (rd_key == item_q.process_id);
  assign sts_o.cnt_last  = (cnt_q == AddrW'(kcdt_pkg::TableDepth - 1));
  assign sts_o.div_done  = div_done;
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

@@ design/kcdt_ctrl.sv @@
// Controller state machine: clearing sweep, probe walk, divide, write-back
// and hand-off to the output register. Depends on kcdt_pkg and the assert header.
`include "keyed_counter_delta_table_assert.svh"
module kcdt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  kcdt_pkg::sts_t sts_i,
  output kcdt_pkg::cmd_t cmd_o
);
  typedef enum logic [3:0] {
    Clear, Idle, Hash, Read, Check, DivGo, Div, Write, Done
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      Clear: begin
        cmd_o.clr = 1'b1;
        if (sts_i.addr_last) begin
          state_d = Idle;
        end
      end
      Idle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = Hash;
        end
      end
      Hash: begin
        cmd_o.start = 1'b1;
        state_d     = Read;
      end
      Read: state_d = Check;
      Check: begin
        if (!sts_i.used || sts_i.match) begin
          cmd_o.sel = 1'b1;
          state_d   = DivGo;
        end else if (sts_i.cnt_last) begin
          cmd_o.mark_full = 1'b1;
          state_d         = Done;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = Read;
        end
      end
      DivGo: begin
        cmd_o.div_start = 1'b1;
        state_d         = Div;
      end
      Div: begin
        if (sts_i.div_done) begin
          state_d = Write;
        end
      end
      Write: begin
        cmd_o.wr = 1'b1;
        state_d  = Done;
      end
      Done: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = Idle;
        end
      end
      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Clear;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != Idle);

  `KCDT_ASSERT(a_done_in_div, sts_i.div_done |-> state_q == Div, "divider done outside Div")
  `KCDT_ASSERT(a_wr_not_clr, cmd_o.wr |-> !cmd_o.clr, "write-back during clearing sweep")
  `KCDT_ASSERT(a_finish_free, cmd_o.finish |-> !sts_i.out_busy, "result overwrites held output")
  `KCDT_ASSERT_ALWAYS(a_rst_clear, !rst_ni |=> state_q == Clear || rst_ni,
                      "reset did not restart the clearing sweep")
endmodule

@@ verif/keyed_counter_delta_table_tb.sv @@
// Self-checking testbench for keyed_counter_delta_table: fault-rate prediction,
// first sightings and stalled counters. Depends on kcdt_pkg and the RTL.
module keyed_counter_delta_table_tb;

  localparam logic [kcdt_pkg::RateW-1:0] RateMax    = '1;
  localparam int                         PoolSize   = 48;
  localparam int                         IdleWait   = 200;
  localparam int                         WatchLimit = 60000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  kcdt_pkg::in_t            in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  kcdt_pkg::out_t           out_data;
  logic                     cfg_we = 1'b0;
  logic [kcdt_pkg::MsW-1:0] cfg_wdata = '0;

  keyed_counter_delta_table i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // The clock runs with a period of 8 time units.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the block's table and of its interval register.
  bit                        shadow_used [kcdt_pkg::TableDepth];
  logic [kcdt_pkg::KeyW-1:0] shadow_key [kcdt_pkg::TableDepth];
  logic [kcdt_pkg::CntW-1:0] shadow_minor [kcdt_pkg::TableDepth];
  logic [kcdt_pkg::CntW-1:0] shadow_major [kcdt_pkg::TableDepth];
  logic [kcdt_pkg::MsW-1:0]  interval_ms = kcdt_pkg::DefaultMs;

  kcdt_pkg::in_t  pending_items [$];
  kcdt_pkg::out_t expected_results [$];
  int             mismatches = 0;
  bit             in_xfer, out_xfer;

  // Per-id history of the counters sent, so random items mostly count upward.
  logic [kcdt_pkg::KeyW-1:0] pool_id [PoolSize];
  logic [kcdt_pkg::CntW-1:0] pool_minor [PoolSize];
  logic [kcdt_pkg::CntW-1:0] pool_major [PoolSize];

  // A rate is floor(diff * 1000 / ms); the product needs 74 bits before
  // the divide, and anything beyond 48 bits saturates.
  function automatic logic [kcdt_pkg::RateW-1:0] faults_per_second(
      logic [kcdt_pkg::CntW-1:0] diff, logic [kcdt_pkg::MsW-1:0] ms);
    logic [kcdt_pkg::DvdW-1:0] q;
    q = (kcdt_pkg::DvdW'(diff) * kcdt_pkg::DvdW'(1000)) / kcdt_pkg::DvdW'(ms);
    return (q > kcdt_pkg::DvdW'(RateMax)) ? RateMax : q[kcdt_pkg::RateW-1:0];
  endfunction

  // Looks the id up by linear probing from its multiplicative hash, inserts
  // it when a free slot comes first, and returns the result the block owes.
  function automatic kcdt_pkg::out_t predict_fault_rates(kcdt_pkg::in_t it);
    kcdt_pkg::out_t             r;
    logic [31:0]                h;
    logic [kcdt_pkg::AddrW-1:0] home, s;
    int                         slot;
    logic [kcdt_pkg::MsW-1:0]   ms;
    logic [kcdt_pkg::CntW-1:0]  pmin, pmaj;
    bit                         min_up, maj_up;
    h = 32'(it.process_id) * kcdt_pkg::HashMul;
    home = h[kcdt_pkg::AddrW-1:0];
    slot = -1;
    for (int i = 0; i < kcdt_pkg::TableDepth; i++) begin
      s = home + kcdt_pkg::AddrW'(i);
      if (!shadow_used[s]) begin
        shadow_used[s] = 1'b1;
        shadow_key[s] = it.process_id;
        shadow_minor[s] = '0;
        shadow_major[s] = '0;
        slot = int'(s);
        break;
      end
      if (shadow_key[s] == it.process_id) begin
        slot = int'(s);
        break;
      end
    end
    ms = (interval_ms == '0) ? kcdt_pkg::DefaultMs : interval_ms;
    r = '0;
    r.echo_process_id = it.process_id;
    r.resident_kb = {it.resident_pages, 2'b00};
    if (slot < 0) begin
      // The table is full: nothing is stored and no rate is given.
      r.status = kcdt_pkg::StFull;
    end else begin
      pmin = shadow_minor[slot];
      pmaj = shadow_major[slot];
      min_up = 1'b0;
      maj_up = 1'b0;
      if (pmin != '0 && it.minor_faults >= pmin) begin
        r.minor_rate = faults_per_second(it.minor_faults - pmin, ms);
        min_up = it.minor_faults > pmin;
      end
      if (pmaj != '0 && it.major_faults >= pmaj) begin
        r.major_rate = faults_per_second(it.major_faults - pmaj, ms);
        maj_up = it.major_faults > pmaj;
      end
      // A zero counter is kept as one so that the slot no longer reads as new.
      shadow_minor[slot] = (it.minor_faults == '0) ? kcdt_pkg::CntW'(1) : it.minor_faults;
      shadow_major[slot] = (it.major_faults == '0) ? kcdt_pkg::CntW'(1) : it.major_faults;
      if (pmin == '0 && pmaj == '0) r.status = kcdt_pkg::StFirst;
      else if (!min_up && !maj_up)  r.status = kcdt_pkg::StNoInc;
      else                          r.status = kcdt_pkg::StReported;
    end
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps. The payload
  // only changes when no transfer is pending, and every accepted item is
  // fed to the predictor at the edge of its transfer.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_fault_rates(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            // About a third of the bursts are followed by no gap at all.
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: the stall pattern is periodically chosen at random among never
  // stalling, stalling at random, and long stretches of stall.
  int stall_phase = 0;
  int stall_mode = 0;

  always @(posedge clk_i) begin
    stall_phase++;
    if (stall_phase % 128 == 0) begin
      stall_mode = $urandom_range(0, 2);
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_stall <= ($urandom_range(0, 7) != 0);
      end
    endcase
  end

  // Result checker: every result transfer is matched with the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    kcdt_pkg::out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: id %h status %0d", out_data.echo_process_id,
                   out_data.status);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status
            || out_data.echo_process_id !== want.echo_process_id
            || out_data.minor_rate !== want.minor_rate
            || out_data.major_rate !== want.major_rate
            || out_data.resident_kb !== want.resident_kb) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch id %h: expected st %0d min %h maj %h kb %h",
                     want.echo_process_id, want.status, want.minor_rate,
                     want.major_rate, want.resident_kb);
            $display("  actual id %h: st %0d min %h maj %h kb %h",
                     out_data.echo_process_id, out_data.status,
                     out_data.minor_rate, out_data.major_rate, out_data.resident_kb);
          end
        end
      end
    end
  end

  // Watchdog: a stretch of WatchLimit cycles with no transfer at all, far longer
  // than a full table walk or the reset sweep, means a hang.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    in_xfer = in_valid && !in_stall;
    out_xfer = out_valid && !out_stall;
    if (in_xfer || out_xfer) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_item(logic [kcdt_pkg::KeyW-1:0] id, logic [kcdt_pkg::CntW-1:0] minor,
                           logic [kcdt_pkg::CntW-1:0] major,
                           logic [kcdt_pkg::PagesW-1:0] pages);
    kcdt_pkg::in_t it;
    it.process_id = id;
    it.minor_faults = minor;
    it.major_faults = major;
    it.resident_pages = pages;
    pending_items.push_back(it);
  endtask

  function automatic logic [kcdt_pkg::CntW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Next counter value for a tracked id: mostly small forward steps, with
  // large jumps, repeats, backward steps, zeros and arbitrary values mixed in.
  function automatic logic [kcdt_pkg::CntW-1:0] next_count(logic [kcdt_pkg::CntW-1:0] last);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return last + kcdt_pkg::CntW'($urandom_range(1, 5000));
    if (pick < 75) return last + rand64();
    if (pick < 83) return last;
    if (pick < 88) return last - kcdt_pkg::CntW'($urandom_range(1, 100));
    if (pick < 93) return '0;
    return rand64();
  endfunction

  task automatic push_random(int count);
    int p;
    logic [kcdt_pkg::PagesW-1:0] pages;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(0, PoolSize - 1);
      pool_minor[p] = next_count(pool_minor[p]);
      pool_major[p] = ($urandom_range(0, 3) == 0) ? next_count(pool_major[p])
                                                   : pool_major[p];
      pages = kcdt_pkg::PagesW'({$urandom, $urandom});
      push_item(pool_id[p], pool_minor[p], pool_major[p], pages);
    end
  endtask

  // Lets all queued items go out, waits for every result, then gives the
  // block time to settle before anything touches the register.
  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  task automatic write_interval(logic [kcdt_pkg::MsW-1:0] ms);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= ms;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    interval_ms = ms;
  endtask

  initial begin
    for (int p = 0; p < PoolSize; p++) begin
      pool_id[p] = kcdt_pkg::KeyW'($urandom_range(1, 23'h3FFFFF));
      pool_minor[p] = '0;
      pool_major[p] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items under the reset interval of 1000 ms.
    push_item(23'h000000, '0, '0, '0);                 // first sighting
    push_item(23'h000000, '0, '0, '0);                 // zero kept as one: no increase
    push_item(23'h000000, 64'd1, 64'd1, 34'd1);        // equal to stored one
    push_item(23'h000000, 64'd2, 64'd5, 34'd2);        // rates reported
    push_item(23'h000000, '1, '1, '1);                 // rate saturates
    push_item(23'h000000, 64'd10, '1, '1);             // minor went backwards
    push_item(23'h000000, 64'd10, 64'd3, '0);          // both backwards or equal
    push_item(23'h7FFFFF, 64'hFFFF_FFFF_FFFF_FFFE, 64'd7, '1);
    push_item(23'h7FFFFF, '1, 64'd7, 34'h2AAAAAAAA);   // one-count increase
    push_item(23'h400000, 64'd5, '0, 34'h155555555);   // first sighting
    push_item(23'h400000, 64'd5, 64'd0, '0);           // no increase
    push_item(23'h400000, 64'd6, 64'd9, '0);           // increase after zero major
    push_item(23'h000001, 64'd100, 64'd100, 34'd4);    // takes its home slot first
    push_item(23'h001001, 64'd50, 64'd50, 34'd4);      // same home slot: probes on
    push_item(23'h001001, 64'd1050, 64'd51, 34'd4);
    push_item(23'h000001, 64'd99, 64'd200, 34'd4);
    drain();

    // Zero interval stands for one second.
    write_interval(16'd0);
    push_item(23'h001001, 64'd3050, 64'd52, 34'd8);
    push_random(170);
    drain();

    write_interval(16'hFFFF);
    push_random(170);
    drain();

    write_interval(16'd1);
    push_item(23'h001001, 64'h0000_0119_0000_0000, 64'd53, 34'd8);
    push_random(170);
    drain();

    write_interval(16'($urandom_range(2, 65534)));
    push_random(170);

    drain();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
